// File: sv/bds_pkg.sv
`default_nettype none

package bds_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;   // run the accepted request against store and pointers
        logic load;   // move the finished result into the output register
    } bds_cmd_t;

endpackage

`default_nettype wire

// File: sv/bds_if.sv
`default_nettype none

interface bds_req_if;
    import bds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface bds_rsp_if;
    import bds_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output data, output count, output status, input ready);
    modport sink   (input valid, input data, input count, input status, output ready);
endinterface

`default_nettype wire

// File: sv/bounded_deque_store.sv
`default_nettype none

// Channel   Role   Payload
// -------   ----   ---------------------------------------------
// req       sink   mode[2:0], position[15:0] s, value[31:0] s
// rsp       source data[31:0] s, count[10:0], status[1:0]
//
// Each item runs through S_IDLE and then S_RESP: the accept in S_IDLE runs the
// store access (one read or one write on the single store port) and the
// pointer update, and S_RESP moves the result into the output register.
// rst_n clears head and element count; the store itself is not cleared.
// A result waiting on rsp does not block accepting the next item; that item
// then waits in S_RESP until the output register frees up.
module bounded_deque_store
    import bds_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bds_req_if.sink   req,
    bds_rsp_if.source rsp
);

    bds_cmd_t cmd;

    // sequence accept and delivery
    bds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // ring buffer store, head/count pointers and output register
    bds_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (req.mode),
        .position (req.position),
        .value    (req.value),
        .data     (rsp.data),
        .count    (rsp.count),
        .status   (rsp.status)
    );

endmodule

`default_nettype wire

// File: sv/bds_ctrl.sv
`default_nettype none

module bds_ctrl
    import bds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output bds_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/bds_datapath.sv
`default_nettype none

module bds_datapath
    import bds_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bds_cmd_t                 cmd,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [POS_W-1:0]  position,
    input  wire logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0]      data,
    output logic [COUNT_W-1:0]            count,
    output logic [STATUS_W-1:0]           status
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W - 1) ? CW : POS_W - 1;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [IW-1:0]       head_reg, head_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic                rd_flag_reg, rd_flag_next;
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    logic          full, empty, pos_neg, pos_in_range;
    logic [CMPW-1:0] pos_ext, cnt_ext;
    logic [IW-1:0] head_dec, head_inc, cnt_last, pos_low;
    logic [IW-1:0] offset, slot, addr;
    logic [IW:0]   sum;
    logic          we, re;

    assign full    = (cnt_reg == CW'(CAPACITY));
    assign empty   = (cnt_reg == '0);
    assign pos_neg = position[POS_W-1];
    assign pos_ext = CMPW'(position[POS_W-2:0]);
    assign cnt_ext = CMPW'(cnt_reg);
    assign pos_in_range = !pos_neg && (pos_ext < cnt_ext);
    assign pos_low  = IW'(position[POS_W-2:0]);
    assign cnt_last = IW'(cnt_reg - 1'b1);
    assign head_dec = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // element offset from the head for the modes that address by position
    always_comb
    begin
        offset = '0;
        case (mode)
            MODE_PUSH_BACK:
            begin
                offset = IW'(cnt_reg);
            end
            MODE_POP_BACK:
            begin
                offset = cnt_last;
            end
            MODE_READ:
            begin
                // clamp: negative reads the front, past the end reads the back
                if (pos_neg)
                begin
                    offset = '0;
                end
                else if (pos_in_range)
                begin
                    offset = pos_low;
                end
                else
                begin
                    offset = cnt_last;
                end
            end
            MODE_WRITE:
            begin
                offset = pos_low;
            end
            default:
            begin
                offset = '0;
            end
        endcase
    end

    // ring slot of element 'offset': both terms below CAPACITY, one subtract wraps
    assign sum  = {1'b0, head_reg} + {1'b0, offset};
    assign slot = (sum >= (IW+1)'(CAPACITY)) ? IW'(sum - (IW+1)'(CAPACITY)) : IW'(sum);

    always_comb
    begin
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        stat_next    = STAT_OK;
        we           = 1'b0;
        re           = 1'b0;
        addr         = slot;
        case (mode)
            MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_PUSH_FRONT:
            begin
                addr = head_dec;
                if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    we        = 1'b1;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            MODE_POP_BACK:
            begin
                if (empty)
                begin
                    stat_next = STAT_EMPTY;
                end
                else
                begin
                    re       = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                addr = head_reg;
                if (empty)
                begin
                    stat_next = STAT_EMPTY;
                end
                else
                begin
                    re        = 1'b1;
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            MODE_READ:
            begin
                if (empty)
                begin
                    stat_next = STAT_EMPTY;
                end
                else
                begin
                    re = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                if (pos_in_range)
                begin
                    we = 1'b1;
                end
                else
                begin
                    stat_next = STAT_BADPOS;
                end
            end
            default:
            begin
                stat_next = STAT_OK;
            end
        endcase
        rd_flag_next = re;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            mem[addr] <= value;
        end
        if (cmd.exec && re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            cnt_reg     <= '0;
            stat_reg    <= STAT_OK;
            rd_flag_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            stat_reg    <= stat_next;
            rd_flag_reg <= rd_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg   <= rd_flag_reg ? rdata_reg : '0;
            out_count_reg  <= COUNT_W'(cnt_reg);
            out_status_reg <= stat_reg;
        end
    end

    assign data   = out_data_reg;
    assign count  = out_count_reg;
    assign status = out_status_reg;

endmodule

`default_nettype wire
